>>> rtl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// Weighted vector merge package
// Shared widths, constants and cell interface types.
// ----------------------------------------------------------------------------
package wvm_pkg;
  localparam int TopCount  = 10;
  localparam int MaxLength = 65536;
  localparam int PosW      = 17;
  localparam int DiffW     = 32;
  localparam int FillW     = $clog2(TopCount + 1);

  typedef enum logic [0:0] {
    CFG_FIRST_LEAVES  = 1'b0,
    CFG_SECOND_LEAVES = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_MERGED = 1'b0,
    KIND_LIST   = 1'b1
  } kind_e;

  // entry carried along the cell chain
  typedef struct packed {
    logic             valid;
    logic [DiffW-1:0] diff;
    logic [PosW-1:0]  pos;
  } entry_t;

  // chain control broadcast to every cell
  typedef struct packed {
    logic insert;  // offer a new entry
    logic shift;   // shift list toward the head (drain)
    logic clear;   // drop all entries
  } cell_ctrl_t;
endpackage

>>> rtl/wvm_cell.sv
// ----------------------------------------------------------------------------
// Weighted vector merge list cell
// One slot of the sorted top-difference list.
// ----------------------------------------------------------------------------
module wvm_cell import wvm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,      // offered entry
  input  entry_t     prev_i,     // entry held by the cell above
  input  logic       prev_take_i, // cell above takes the new entry or passed it down
  input  entry_t     next_i,     // entry held by the cell below
  output entry_t     entry_o,
  output logic       take_o
);
  entry_t entry_q, entry_d;

  // new entry ranks ahead of the held one (equal diff keeps earlier position)
  assign take_o = !entry_q.valid || (new_i.diff > entry_q.diff);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d = '0;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end else if (ctrl_i.insert) begin
      if (prev_take_i) begin
        entry_d = prev_i;
      end else if (take_o) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

>>> rtl/wvm_div.sv
// ----------------------------------------------------------------------------
// Weighted vector merge divider
// Restoring signed divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvm_div import wvm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [49:0] num_i,
  input  logic [16:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  logic [49:0] rem_q, rem_d;
  logic [49:0] quo_q, quo_d;
  logic [16:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [50:0] trial;
  logic [49:0] qsigned;

  assign trial = {rem_q, quo_q[49]} - {34'd0, den_q};

  always_comb begin
    rem_d = trial[50] ? {rem_q[48:0], quo_q[49]} : trial[49:0];
    quo_d = {quo_q[48:0], !trial[50]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd50;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[49] ? 50'(-num_i) : 50'(num_i);
      den_q <= den_i;
      neg_q <= num_i[49];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign qsigned = neg_q ? 50'(-quo_q) : quo_q;
  assign quot_o  = qsigned[31:0];
endmodule

>>> rtl/weighted_vector_merge_top_k.sv
// ----------------------------------------------------------------------------
// Weighted vector merge with top-k difference list
// Top level: element merge, list chain and result sequencing.
// ----------------------------------------------------------------------------
// Use: write first_leaves (index 0) and second_leaves (index 1) on the cfg
// channel before a merge, then stream element pairs on the in channel; mark
// the final pair with last_element. Each pair yields one merged word; an
// equal pair passes the first element through. Unequal pairs offer their
// absolute difference to a sorted chain of TopCount cells, which takes the
// entry in the merge state. After the final pair's merged word, the list drains
// from the head, largest difference first, one word per taken cycle; run_end
// marks the last word of each merge.
// An unequal pair's merged word passes the weighted sum register, the divider
// start, the bit-serial divider, its done pulse and the output register;
// an equal pair's word goes straight to the output register.
// One item is worked on at a time: the next pair is taken the cycle after the
// last word of the previous one leaves, so the divider sets the rate.
// Reset clears the list, the counters, the merge number and sets both leaf
// counts to 1. When the receiver stalls, the output word holds and the block
// takes no new item until the word and any list words are delivered.
// ----------------------------------------------------------------------------
module weighted_vector_merge_top_k import wvm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic signed [31:0] merged_value_o,
  output logic [31:0]        top_difference_o,
  output logic [16:0]        top_position_o,
  output logic [16:0]        contributing_count_o,
  output logic [15:0]        merge_number_o,
  output logic               run_end_o
);
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e state_q;
  logic [15:0] first_leaves_q, second_leaves_q;
  logic [PosW-1:0] pair_q, unequal_q;
  logic [15:0] seq_q;
  logic [FillW-1:0] fill_q;
  logic last_q;
  logic signed [31:0] a_q, b_q;

  // config: accepted always, written only while idle by contract
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_leaves_q  <= 16'd1;
      second_leaves_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_LEAVES:  first_leaves_q  <= cfg_data_i;
        CFG_SECOND_LEAVES: second_leaves_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic in_acc, out_acc;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_o;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  // weighted sum: computed from the held operands, registered numerator
  logic [16:0] c1, c2;
  logic signed [49:0] num_q;
  logic [16:0] den_q;
  logic        div_arm_q;
  logic        div_start_q;
  assign c1 = (first_leaves_q == '0)  ? 17'd1 : {1'b0, first_leaves_q};
  assign c2 = (second_leaves_q == '0) ? 17'd1 : {1'b0, second_leaves_q};

  logic signed [49:0] prod_a, prod_b;
  assign prod_a = 50'(a_q) * $signed({1'b0, c1});
  assign prod_b = 50'(b_q) * $signed({1'b0, c2});

  logic div_done;
  logic signed [31:0] quot;
  wvm_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start_q), .num_i(num_q), .den_i(den_q),
    .done_o(div_done), .quot_o(quot)
  );

  // position and difference of the current pair
  logic [PosW-1:0] pos;
  logic [32:0] dwide;
  assign pos   = (pair_q == PosW'(MaxLength)) ? PosW'(MaxLength) : pair_q + PosW'(1);
  assign dwide = (a_q > b_q) ? 33'(a_q) - 33'(b_q) : 33'(b_q) - 33'(a_q);

  // cell chain
  cell_ctrl_t ctrl;
  entry_t new_e;
  entry_t cells [TopCount];
  logic   take [TopCount];
  logic   can_insert;

  assign new_e      = '{valid: 1'b1, diff: dwide[31:0], pos: pos};
  assign can_insert = !cells[TopCount-1].valid || (new_e.diff > cells[TopCount-1].diff);

  for (genvar g = 0; g < TopCount; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_take;
    if (g == 0) begin : g_head
      assign prev_e = '0;
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_e = cells[g-1];
      assign prev_take = take[g-1];
    end
    if (g == TopCount - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[g+1];
    end
    wvm_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .new_i(new_e),
      .prev_i(prev_e), .prev_take_i(prev_take), .next_i(next_e),
      .entry_o(cells[g]), .take_o(take[g])
    );
  end

  logic unequal;
  assign unequal = (a_q != b_q);

  always_comb begin
    ctrl = '0;
    if (state_q == ST_MERGE && unequal && can_insert) ctrl.insert = 1'b1;
    if (state_q == ST_DRAIN && out_acc && result_kind_o == KIND_LIST) ctrl.shift = 1'b1;
  end

  // control and output register
  logic [FillW-1:0] fill_after;
  assign fill_after = (unequal && fill_q != FillW'(TopCount)) ? fill_q + FillW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
      pair_q      <= '0;
      unequal_q   <= '0;
      seq_q       <= '0;
      fill_q      <= '0;
      div_arm_q   <= 1'b0;
      div_start_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      // divider start pulse comes from the arm register, high while the numerator register holds the pair
      div_arm_q   <= 1'b0;
      div_start_q <= div_arm_q;
      if (out_acc && state_q != ST_DRAIN) out_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q    <= last_element_i;
            div_arm_q <= (first_value_i != second_value_i);
            state_q   <= (first_value_i != second_value_i) ? ST_DIV : ST_MERGE;
          end
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          if (pair_q != PosW'(MaxLength)) pair_q <= pair_q + PosW'(1);
          if (unequal && unequal_q != PosW'(MaxLength)) unequal_q <= unequal_q + PosW'(1);
          fill_q      <= fill_after;
          out_valid_o <= 1'b1;
          state_q     <= (last_q && fill_after != '0) ? ST_DRAIN : ST_IDLE;
          if (last_q && fill_after == '0) begin
            pair_q    <= '0;
            unequal_q <= '0;
            seq_q     <= seq_q + 16'd1;
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            if (result_kind_o == KIND_LIST && fill_q == FillW'(1)) begin
              out_valid_o <= 1'b0;
              fill_q      <= '0;
              pair_q      <= '0;
              unequal_q   <= '0;
              seq_q       <= seq_q + 16'd1;
              state_q     <= ST_IDLE;
            end else if (result_kind_o == KIND_LIST) begin
              fill_q <= fill_q - FillW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= first_value_i;
      b_q <= second_value_i;
    end
  end

  // numerator/denominator: registered from held operands ahead of start
  logic signed [49:0] num_c;
  assign num_c = prod_a + prod_b;
  always_ff @(posedge clk_i) begin
    num_q <= num_c;
    den_q <= c1 + c2;
  end

  // result word
  entry_t head;
  assign head = cells[0];
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MERGE) begin
      result_kind_o        <= KIND_MERGED;
      merged_value_o       <= unequal ? quot : a_q;
      top_difference_o     <= '0;
      top_position_o       <= '0;
      contributing_count_o <= (unequal && unequal_q != PosW'(MaxLength))
                              ? unequal_q + PosW'(1) : unequal_q;
      merge_number_o       <= seq_q + 16'd1;
      run_end_o            <= last_q && fill_after == '0;
    end else if (state_q == ST_DRAIN && out_acc) begin
      result_kind_o    <= KIND_LIST;
      merged_value_o   <= '0;
      top_difference_o <= (result_kind_o == KIND_LIST) ? cells[1].diff : head.diff;
      top_position_o   <= (result_kind_o == KIND_LIST) ? cells[1].pos : head.pos;
      run_end_o        <= (result_kind_o == KIND_LIST) ? (fill_q == FillW'(2))
                                                       : (fill_q == FillW'(1));
    end
  end

  // list clears itself: drain shifts in zeros from the tail
`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TopCount)) else $error("list fill beyond capacity");
  a_busy_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o) else $error("input taken while busy");
  a_drain_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> fill_q != '0) else $error("drain with empty list");
`endif
endmodule

>>> bench/merge_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted merge checker
// Watches the config, input and output channels, predicts every output word
// of the weighted vector merge and compares it field by field.
// ----------------------------------------------------------------------------
module merge_check import wvm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic               last_element_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               result_kind_i,
  input  logic signed [31:0] merged_value_i,
  input  logic [31:0]        top_difference_i,
  input  logic [16:0]        top_position_i,
  input  logic [16:0]        contributing_count_i,
  input  logic [15:0]        merge_number_i,
  input  logic               run_end_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] merged;
    logic [31:0] diff;
    logic [16:0] pos;
    logic [16:0] count;
    logic [15:0] merge_no;
    logic        run_end;
  } word_t;

  word_t       words_due[$];
  logic [15:0] leaves_a, leaves_b;
  logic [31:0] top_diff [TopCount];
  logic [16:0] top_pos  [TopCount];
  int unsigned top_fill, pair_cnt, unequal_cnt;
  logic [15:0] merges_done;

  assign pending_o = words_due.size();

  // keep the list sorted by difference descending, position ascending
  function automatic void rank_entry(logic [31:0] d, logic [16:0] p);
    int j;
    if (top_fill >= TopCount) begin
      if (d <= top_diff[TopCount-1]) return;
      top_fill = TopCount - 1;
    end
    j = 0;
    while (j < top_fill && top_diff[j] >= d) j++;
    for (int k = top_fill; k > j; k--) begin
      top_diff[k] = top_diff[k-1];
      top_pos[k]  = top_pos[k-1];
    end
    top_diff[j] = d;
    top_pos[j]  = p;
    top_fill++;
  endfunction

  function automatic void predict_pair(logic signed [31:0] fa, logic signed [31:0] fb,
                                       logic last);
    longint a, b, c1, c2, mean;
    int unsigned p;
    word_t w;
    a  = fa;
    b  = fb;
    c1 = (leaves_a == 0) ? 1 : leaves_a;
    c2 = (leaves_b == 0) ? 1 : leaves_b;
    p  = (pair_cnt + 1 > MaxLength) ? MaxLength : pair_cnt + 1;
    if (pair_cnt < MaxLength) pair_cnt++;
    if (a == b) begin
      mean = a;
    end else begin
      mean = (c1 * a + c2 * b) / (c1 + c2);
      if (unequal_cnt < MaxLength) unequal_cnt++;
      rank_entry(32'((a > b) ? a - b : b - a), 17'(p));
    end
    w = '{KIND_MERGED, 32'(mean), 32'd0, 17'd0, 17'(unequal_cnt), merges_done + 16'd1,
          last && top_fill == 0};
    words_due.push_back(w);
    if (last) begin
      for (int i = 0; i < top_fill; i++) begin
        w = '{KIND_LIST, 32'd0, top_diff[i], top_pos[i], 17'(unequal_cnt),
              merges_done + 16'd1, (i + 1 == top_fill)};
        words_due.push_back(w);
      end
      for (int i = 0; i < TopCount; i++) begin
        top_diff[i] = '0;
        top_pos[i]  = '0;
      end
      top_fill    = 0;
      pair_cnt    = 0;
      unequal_cnt = 0;
      merges_done++;
    end
  endfunction

  task automatic flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    leaves_a = 16'd1;
    leaves_b = 16'd1;
    top_fill = 0;
    pair_cnt = 0;
    unequal_cnt = 0;
    merges_done = '0;
    for (int i = 0; i < TopCount; i++) begin
      top_diff[i] = '0;
      top_pos[i]  = '0;
    end
  end

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_FIRST_LEAVES) leaves_a = cfg_data_i;
        else leaves_b = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) predict_pair(first_value_i, second_value_i, last_element_i);
      if (out_valid_i && out_ready_i) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d value 0x%0h",
                   $time, result_kind_i, merged_value_i);
          fail_count_o++;
        end else begin
          w = words_due.pop_front();
          if (result_kind_i !== w.kind) flag("result_kind", w.kind, result_kind_i);
          if (merged_value_i !== w.merged) flag("merged_value", w.merged, merged_value_i);
          if (top_difference_i !== w.diff) flag("top_difference", w.diff, top_difference_i);
          if (top_position_i !== w.pos) flag("top_position", w.pos, top_position_i);
          if (contributing_count_i !== w.count)
            flag("contributing_count", w.count, contributing_count_i);
          if (merge_number_i !== w.merge_no) flag("merge_number", w.merge_no, merge_number_i);
          if (run_end_i !== w.run_end) flag("run_end", w.run_end, run_end_i);
        end
      end
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted vector merge testbench
// Drives leaf counts and element pairs into the merge block, stalls the
// output at random and lets the checker grade every word.
// ----------------------------------------------------------------------------
module tb import wvm_pkg::*;;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] first_value_i = '0;
  logic signed [31:0] second_value_i = '0;
  logic               last_element_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               result_kind_o;
  logic signed [31:0] merged_value_o;
  logic [31:0]        top_difference_o;
  logic [16:0]        top_position_o;
  logic [16:0]        contributing_count_o;
  logic [15:0]        merge_number_o;
  logic               run_end_o;
  int                 pending, fail_count;

  // no_idle is shared by sender and receiver; long holds stall only the receiver
  bit no_idle = 1'b0;
  int long_holds_asked = 0;

  always #10 clk_i = ~clk_i;

  weighted_vector_merge_top_k dut (.*);

  merge_check checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .first_value_i, .second_value_i, .last_element_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_kind_i(result_kind_o),
    .merged_value_i(merged_value_o), .top_difference_i(top_difference_o),
    .top_position_i(top_position_o), .contributing_count_i(contributing_count_o),
    .merge_number_i(merge_number_o), .run_end_i(run_end_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // Receiver: after each taken word draw a random stall unless no_idle is set; on request
  // hold off for a long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    static int hold = 0;
    static int long_done = 0;
    if (rst_ni) begin
      if (long_done < long_holds_asked) begin
        long_done++;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i && !no_idle) begin
        hold = $urandom_range(0, 6);
        out_ready_i <= (hold == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one word on the in channel; hold valid through the stall, then
  // drop it only when a gap follows.
  task automatic push_pair(logic signed [31:0] a, logic signed [31:0] b, logic last);
    int gap;
    in_valid_i     <= 1'b1;
    first_value_i  <= a;
    second_value_i <= b;
    last_element_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Keep valid high on return; the caller drops it after its last write.
  task automatic write_leaves(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Wait for the block to drain before touching the leaf counts.
  task automatic settle_then_config(logic [15:0] la, logic [15:0] lb);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    write_leaves(CFG_FIRST_LEAVES, la);
    write_leaves(CFG_SECOND_LEAVES, lb);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_leaves();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 8));
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    int len;
    logic signed [31:0] a, b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero leaf counts read as one, extremes of the operands
    write_leaves(CFG_FIRST_LEAVES, 16'd0);
    write_leaves(CFG_SECOND_LEAVES, 16'd0);
    cfg_valid_i <= 1'b0;
    push_pair(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
    push_pair(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    push_pair(32'sh80000000, 32'sh80000000, 1'b0);
    push_pair(-32'sd7, 32'sd4, 1'b1);
    // a merge with no unequal pair leaves the list empty
    push_pair(32'sd3, 32'sd3, 1'b1);

    // overfill the list with equal differences; the larger one evicts the
    // latest tie, an equal one is refused
    settle_then_config(16'hFFFF, 16'd1);
    for (int i = 0; i < 10; i++) push_pair(32'sd5, 32'sd0, 1'b0);
    push_pair(32'sd0, 32'sd100, 1'b0);
    push_pair(32'sd5, 32'sd0, 1'b0);
    push_pair(32'sh7FFFFFFF, 32'sh7FFFFFFE, 1'b1);

    // random merges, mostly well formed, new leaf counts between some
    for (int n = 0; n < 100; ) begin
      if ($urandom_range(0, 2) == 0) settle_then_config(pick_leaves(), pick_leaves());
      if (n > 40 && n < 60) long_holds_asked = 1;
      no_idle = ($urandom_range(0, 5) == 0);
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        a = pick_value();
        b = ($urandom_range(0, 3) == 0) ? a : pick_value();
        push_pair(a, b, i == len - 1);
        n++;
      end
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
